// ----- design/quad_scanline_span_fill_defines.svh -----
// Assertion macros used by the quad scanline span fill top level.
`ifndef QUAD_SCANLINE_SPAN_FILL_DEFINES_SVH
`define QUAD_SCANLINE_SPAN_FILL_DEFINES_SVH

// Condition that must hold at every clock edge out of reset.
`define QSF_ASSERT_CLK(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Same-cycle implication.
`define QSF_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define QSF_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/qsf_pkg.sv -----
// Package with constants, types and state encodings of the quad scanline span fill.
package qsf_pkg;

	localparam int ROWS    = 34;
	localparam int COLS    = 90;
	localparam int CRD_W   = 12;
	localparam int ROW_W   = 6;
	localparam int COL_W   = 7;
	localparam int CODE_W  = 8;
	localparam int X_W     = CRD_W + 1;
	localparam int NUM_W   = 2 * X_W + 1;
	localparam int QUO_W   = CRD_W;
	localparam int DCNT_W  = $clog2(QUO_W);
	localparam int CNT_W   = 3;

	localparam logic signed [X_W-1:0] ROWS_S   = X_W'(ROWS);
	localparam logic signed [X_W-1:0] ROWS_MAX = X_W'(ROWS - 1);
	localparam logic signed [X_W-1:0] COLS_MAX = X_W'(COLS - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RANGE,
		ST_EDGE,
		ST_WAIT,
		ST_EMIT
	} seq_state_t;

	typedef enum logic [2:0] {
		XS_IDLE,
		XS_MUL1,
		XS_MUL2,
		XS_ABS,
		XS_DIV,
		XS_DONE
	} xs_state_t;

	typedef struct packed {
		logic                    start;
		logic signed [CRD_W-1:0] ax;
		logic signed [CRD_W-1:0] ay;
		logic signed [CRD_W-1:0] bx;
		logic signed [CRD_W-1:0] by;
		logic [ROW_W-1:0]        y;
	} xu_req_t;

	typedef struct packed {
		logic                  busy;
		logic                  done;
		logic signed [X_W-1:0] x;
	} xu_rsp_t;

endpackage

// ----- design/qsf_ifs.sv -----
// Valid/ready channel interfaces for quad beats in and span beats out.
interface qsf_in_if;
	import qsf_pkg::*;

	logic                    valid;
	logic                    ready;
	logic signed [CRD_W-1:0] x0;
	logic signed [CRD_W-1:0] y0;
	logic signed [CRD_W-1:0] x1;
	logic signed [CRD_W-1:0] y1;
	logic signed [CRD_W-1:0] x2;
	logic signed [CRD_W-1:0] y2;
	logic signed [CRD_W-1:0] x3;
	logic signed [CRD_W-1:0] y3;
	logic                    all_valid;
	logic [CODE_W-1:0]       fill_code;

	modport source (output valid, x0, y0, x1, y1, x2, y2, x3, y3, all_valid, fill_code,
		input ready);
	modport sink (input valid, x0, y0, x1, y1, x2, y2, x3, y3, all_valid, fill_code,
		output ready);
endinterface

interface qsf_out_if;
	import qsf_pkg::*;

	logic              valid;
	logic              ready;
	logic [ROW_W-1:0]  row;
	logic [COL_W-1:0]  span_start;
	logic [COL_W-1:0]  span_end;
	logic              span_valid;
	logic [CODE_W-1:0] paint_code;
	logic              last;

	modport source (output valid, row, span_start, span_end, span_valid, paint_code, last,
		input ready);
	modport sink (input valid, row, span_start, span_end, span_valid, paint_code, last,
		output ready);
endinterface

// ----- design/qsf_xcross.sv -----
// Edge crossing unit: one shared multiplier and a restoring divider, one quotient bit a cycle.
module qsf_xcross (
	input  logic              clk,
	input  logic              arst_n,
	input  qsf_pkg::xu_req_t  req,
	output qsf_pkg::xu_rsp_t  rsp
);
	import qsf_pkg::*;

	xs_state_t               state_q, state_d;
	logic signed [X_W-1:0]   ax_q, d_q, dy_q, dx_q;
	logic signed [NUM_W-1:0] acc_q;
	logic                    neg_q;
	logic [CRD_W-1:0]        dmag_q;
	logic [CRD_W-1:0]        rem_q;
	logic [QUO_W-1:0]        quo_q;
	logic [DCNT_W-1:0]       cnt_q;

	logic signed [X_W-1:0]     mul_a, mul_b;
	logic signed [2*X_W-1:0]   prod;
	logic signed [NUM_W-1:0]   acc_abs;
	logic signed [X_W-1:0]     d_abs;
	logic [CRD_W:0]            trial;
	logic                      ge;

	assign mul_a   = (state_q == XS_MUL1) ? ax_q : dy_q;
	assign mul_b   = (state_q == XS_MUL1) ? d_q : dx_q;
	assign prod    = mul_a * mul_b;
	assign acc_abs = acc_q[NUM_W-1] ? -acc_q : acc_q;
	assign d_abs   = d_q[X_W-1] ? -d_q : d_q;
	assign trial   = {rem_q, quo_q[QUO_W-1]};
	assign ge      = trial >= {1'b0, dmag_q};

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			XS_IDLE: if (req.start) state_d = XS_MUL1;
			XS_MUL1: state_d = XS_MUL2;
			XS_MUL2: state_d = XS_ABS;
			XS_ABS:  state_d = XS_DIV;
			XS_DIV:  if (cnt_q == DCNT_W'(QUO_W - 1)) state_d = XS_DONE;
			XS_DONE: state_d = XS_IDLE;
			default: state_d = XS_IDLE;
		endcase
	end

	always_comb begin
		rsp.busy = (state_q != XS_IDLE);
		rsp.done = (state_q == XS_DONE);
		rsp.x    = neg_q ? -X_W'(quo_q) : X_W'(quo_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= XS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			XS_IDLE: begin
				if (req.start) begin
					ax_q <= X_W'(req.ax);
					d_q  <= X_W'(req.by) - X_W'(req.ay);
					dy_q <= $signed(X_W'(req.y)) - X_W'(req.ay);
					dx_q <= X_W'(req.bx) - X_W'(req.ax);
				end
			end
			XS_MUL1: acc_q <= NUM_W'(prod);
			XS_MUL2: acc_q <= acc_q + NUM_W'(prod);
			XS_ABS: begin
				neg_q  <= acc_q[NUM_W-1] ^ d_q[X_W-1];
				dmag_q <= d_abs[CRD_W-1:0];
				rem_q  <= acc_abs[QUO_W+CRD_W-1:QUO_W];
				quo_q  <= acc_abs[QUO_W-1:0];
				cnt_q  <= '0;
			end
			XS_DIV: begin
				rem_q <= ge ? CRD_W'(trial - {1'b0, dmag_q}) : trial[CRD_W-1:0];
				quo_q <= {quo_q[QUO_W-2:0], ge};
				cnt_q <= cnt_q + 1'b1;
			end
			XS_DONE: begin
			end
			default: begin
			end
		endcase
	end

endmodule

// ----- design/quad_scanline_span_fill.sv -----
// Top level of the quad scanline span fill: row sequencer, edge unit and output register.
// A quad beat scans its rows in order; each edge that crosses a row runs the shared multiply
// and 12-step divide of the edge unit. One quad is in work at a time.
// The first span beat follows acceptance through the range state, any edge and wait states,
// the emit state and the output register; a held output stalls the rows.
// Reset clears the sequencer, the edge unit state and the output valid.
`include "quad_scanline_span_fill_defines.svh"

module quad_scanline_span_fill (
	input logic      clk,
	input logic      arst_n,
	qsf_in_if.sink   quad,
	qsf_out_if.source span
);
	import qsf_pkg::*;

	seq_state_t              state_q, state_d;
	logic signed [CRD_W-1:0] px_q [4];
	logic signed [CRD_W-1:0] py_q [4];
	logic                    all_valid_q;
	logic [CODE_W-1:0]       code_q;
	logic [ROW_W-1:0]        row_q, hi_q;
	logic [1:0]              e_q;
	logic [CNT_W-1:0]        cnt_q;
	logic signed [X_W-1:0]   mn_q, mx_q;

	logic                    out_vld_q;
	logic [ROW_W-1:0]        out_row_q;
	logic [COL_W-1:0]        out_s_q, out_e_q;
	logic                    out_ok_q, out_last_q;
	logic [CODE_W-1:0]       out_code_q;

	xu_req_t                 xu_req;
	xu_rsp_t                 xu_rsp;

	logic signed [X_W-1:0]   lo_w, hi_w, ys, ay_w, by_w;
	logic                    blank, in_rng, adv, hit, load_out, is_last;
	logic signed [X_W-1:0]   s_w, e_w;
	logic                    ok_w;

	qsf_xcross u_xcross (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (xu_req),
		.rsp    (xu_rsp)
	);

	always_comb begin
		lo_w = ROWS_S;
		hi_w = '0;
		for (int i = 0; i < 4; i++) begin
			if (X_W'(py_q[i]) < lo_w) lo_w = X_W'(py_q[i]);
			if (X_W'(py_q[i]) > hi_w) hi_w = X_W'(py_q[i]);
		end
		if (lo_w < 0) lo_w = '0;
		if (hi_w > ROWS_MAX) hi_w = ROWS_MAX;
		blank = !all_valid_q || (lo_w > hi_w);
	end

	assign ys     = $signed(X_W'(row_q));
	assign ay_w   = X_W'(py_q[0]);
	assign by_w   = X_W'(py_q[1]);
	assign in_rng = (ay_w != by_w) &&
		((ys >= ay_w && ys < by_w) || (ys >= by_w && ys < ay_w));
	assign is_last = (row_q == hi_q);

	assign s_w  = (mn_q < 0) ? '0 : mn_q;
	assign e_w  = (mx_q > COLS_MAX) ? COLS_MAX : mx_q;
	assign ok_w = (cnt_q >= CNT_W'(2)) && (s_w <= e_w);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (quad.valid) state_d = ST_RANGE;
			ST_RANGE: state_d = blank ? ST_EMIT : ST_EDGE;
			ST_EDGE: begin
				if (in_rng) state_d = ST_WAIT;
				else if (e_q == 2'd3) state_d = ST_EMIT;
			end
			ST_WAIT: begin
				if (xu_rsp.done) state_d = (e_q == 2'd3) ? ST_EMIT : ST_EDGE;
			end
			ST_EMIT: begin
				if (load_out) state_d = is_last ? ST_IDLE : ST_EDGE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		quad.ready   = (state_q == ST_IDLE);
		xu_req.start = (state_q == ST_EDGE) && in_rng;
		xu_req.ax    = px_q[0];
		xu_req.ay    = py_q[0];
		xu_req.bx    = px_q[1];
		xu_req.by    = py_q[1];
		xu_req.y     = row_q;
		hit          = (state_q == ST_WAIT) && xu_rsp.done;
		adv          = ((state_q == ST_EDGE) && !in_rng) || hit;
		load_out     = (state_q == ST_EMIT) && (!out_vld_q || span.ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_vld_q <= 1'b1;
			end else if (span.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (quad.valid && quad.ready) begin
			px_q[0]     <= quad.x0;
			py_q[0]     <= quad.y0;
			px_q[1]     <= quad.x1;
			py_q[1]     <= quad.y1;
			px_q[2]     <= quad.x2;
			py_q[2]     <= quad.y2;
			px_q[3]     <= quad.x3;
			py_q[3]     <= quad.y3;
			all_valid_q <= quad.all_valid;
			code_q      <= quad.fill_code;
		end
		if (state_q == ST_RANGE) begin
			row_q <= blank ? '0 : lo_w[ROW_W-1:0];
			hi_q  <= blank ? '0 : hi_w[ROW_W-1:0];
			cnt_q <= '0;
			e_q   <= '0;
		end
		if (adv) begin
			for (int i = 0; i < 4; i++) begin
				px_q[i] <= px_q[(i + 1) % 4];
				py_q[i] <= py_q[(i + 1) % 4];
			end
			e_q <= e_q + 1'b1;
		end
		if (hit) begin
			if (cnt_q == '0 || xu_rsp.x < mn_q) mn_q <= xu_rsp.x;
			if (cnt_q == '0 || xu_rsp.x > mx_q) mx_q <= xu_rsp.x;
			cnt_q <= cnt_q + 1'b1;
		end
		if (load_out) begin
			out_row_q  <= row_q;
			out_s_q    <= ok_w ? s_w[COL_W-1:0] : '0;
			out_e_q    <= ok_w ? e_w[COL_W-1:0] : '0;
			out_ok_q   <= ok_w;
			out_last_q <= is_last;
			out_code_q <= code_q;
			if (!is_last) begin
				row_q <= row_q + 1'b1;
				cnt_q <= '0;
			end
		end
	end

	assign span.valid      = out_vld_q;
	assign span.row        = out_row_q;
	assign span.span_start = out_s_q;
	assign span.span_end   = out_e_q;
	assign span.span_valid = out_ok_q;
	assign span.paint_code = out_code_q;
	assign span.last       = out_last_q;

	`QSF_ASSERT_IMP(a_start_idle, xu_req.start, !xu_rsp.busy, "Edge unit started while busy.")
	`QSF_ASSERT_IMP(a_done_in_wait, xu_rsp.done, state_q == ST_WAIT, "Crossing done outside wait.")
	`QSF_ASSERT_IMP(a_cnt_range, state_q != ST_IDLE && state_q != ST_RANGE,
		cnt_q <= CNT_W'(4), "More than four crossings on a row.")
	`QSF_ASSERT_NXT(a_load_shows, load_out, span.valid, "Loaded span beat not presented.")

endmodule
